[src/peak_normalize_buffer_assert.svh]
// ----------------------------------------------------------------------------
// peak_normalize_buffer_assert
// assertion macros used by the peak normalize buffer module
// ----------------------------------------------------------------------------
`ifndef PEAK_NORMALIZE_BUFFER_ASSERT_SVH
`define PEAK_NORMALIZE_BUFFER_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define PNB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PNB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pnb_pkg.sv]
// ----------------------------------------------------------------------------
// pnb_pkg
// constants, codes and shared types of the peak normalize buffer
// ----------------------------------------------------------------------------
package pnb_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int SAMPLE_WIDTH = 16;

    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int STEP_W = $clog2(SAMPLE_WIDTH);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] MODE_MONO = 2'd1;

    typedef struct packed {
        logic                    start;
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [SAMPLE_WIDTH-1:0] peak;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [SAMPLE_WIDTH-1:0] result;
    } t_div_rsp;

endpackage

[src/peak_normalize_buffer.sv]
// ----------------------------------------------------------------------------
// peak_normalize_buffer
// planar mono/stereo sample store with peak tracking; fetches return each
// stored sample divided by the peak in the same fixed-point format
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_op, i_channel, i_sample_in
//  out       output     o_out_valid / i_out_ready  o_sample_out, o_out_channel,
//                                                  o_last_sample, o_exhausted
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (num_channels)
//
//  load, clear and no-op beats complete as they are taken and keep o_in_ready high
//  a fetch beat holds o_in_ready low until its result is handed off: a ram
//  read, a divider load, one quotient bit per cycle in the serial divider,
//  taking the quotient, and a handoff into the output register
//  an exhausted fetch skips the divider and goes straight to the handoff
//  a result waiting in the output register stalls only the next fetch handoff
//  synchronous active-low reset clears counts, peak and read position; the
//  sample store has no reset and needs no clearing pass
// ----------------------------------------------------------------------------
module peak_normalize_buffer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [1:0]                              i_op,
    input  logic                                    i_channel,
    input  logic signed [pnb_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [pnb_pkg::SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                                    o_out_channel,
    output logic                                    o_last_sample,
    output logic                                    o_exhausted,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [1:0]                              i_cfg_data
);
    import pnb_pkg::*;

    `include "peak_normalize_buffer_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    typedef struct packed {
        logic             found;
        logic             ch;
        logic [CNT_W-1:0] idx;
    } t_loc;

    // first stored sample at or after (ch, idx) in fetch order
    function automatic t_loc locate(input logic ch, input logic [CNT_W-1:0] idx,
                                    input logic stereo, input logic [CNT_W-1:0] lc,
                                    input logic [CNT_W-1:0] rc);
        t_loc l;
        l.found = 1'b0;
        l.ch    = 1'b0;
        l.idx   = '0;
        if (!ch) begin
            if (idx < lc) begin
                l.found = 1'b1;
                l.idx   = idx;
            end else if (stereo && (rc != '0)) begin
                l.found = 1'b1;
                l.ch    = 1'b1;
            end
        end else if (stereo && (idx < rc)) begin
            l.found = 1'b1;
            l.ch    = 1'b1;
            l.idx   = idx;
        end
        return l;
    endfunction

    logic [1:0]              r_state, n_state;
    logic [1:0]              r_mode, n_mode;
    logic [SAMPLE_WIDTH-1:0] r_peak, n_peak;
    logic [CNT_W-1:0]        r_left_cnt, n_left_cnt;
    logic [CNT_W-1:0]        r_right_cnt, n_right_cnt;
    logic                    r_rd_ch, n_rd_ch;
    logic [CNT_W-1:0]        r_rd_idx, n_rd_idx;
    logic [SAMPLE_WIDTH-1:0] r_pend_sample, n_pend_sample;
    logic                    r_pend_ch, n_pend_ch;
    logic                    r_pend_last, n_pend_last;
    logic                    r_pend_exh, n_pend_exh;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample, n_out_sample;
    logic                    r_out_ch, n_out_ch;
    logic                    r_out_last, n_out_last;
    logic                    r_out_exh, n_out_exh;

    logic                    in_accept;
    logic                    stereo;
    t_loc                    cur_loc;
    t_loc                    nxt_loc;
    logic [CNT_W-1:0]        ld_cnt;
    logic                    ld_drop;
    logic [SAMPLE_WIDTH-1:0] ld_mag;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign stereo      = (r_mode != MODE_MONO);

    always_comb begin
        cur_loc = locate(r_rd_ch, r_rd_idx, stereo, r_left_cnt, r_right_cnt);
        nxt_loc = locate(r_rd_ch, r_rd_idx, stereo, r_left_cnt, r_right_cnt);
        ld_cnt  = i_channel ? r_right_cnt : r_left_cnt;
        ld_drop = (i_channel && !stereo) || (ld_cnt >= CNT_W'(BUFFER_DEPTH));
        ld_mag  = i_sample_in[SAMPLE_WIDTH-1] ? (~i_sample_in + 1'b1) : i_sample_in;
    end

    assign ram_we    = in_accept && (i_op == OP_LOAD) && !ld_drop;
    assign ram_waddr = {i_channel, ld_cnt[IDX_W-1:0]};
    assign ram_raddr = {cur_loc.ch, cur_loc.idx[IDX_W-1:0]};

    pnb_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (2 * BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_sample_in),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign div_req.start  = (r_state == S_READ);
    assign div_req.sample = ram_rdata;
    assign div_req.peak   = r_peak;

    pnb_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_peak        = r_peak;
        n_left_cnt    = r_left_cnt;
        n_right_cnt   = r_right_cnt;
        n_rd_ch       = r_rd_ch;
        n_rd_idx      = r_rd_idx;
        n_pend_sample = r_pend_sample;
        n_pend_ch     = r_pend_ch;
        n_pend_last   = r_pend_last;
        n_pend_exh    = r_pend_exh;
        n_out_valid   = r_out_valid;
        n_out_sample  = r_out_sample;
        n_out_ch      = r_out_ch;
        n_out_last    = r_out_last;
        n_out_exh     = r_out_exh;

        if (i_cfg_valid && o_cfg_ready) begin
            n_mode = i_cfg_data;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_op)
                        OP_LOAD: begin
                            if (!ld_drop) begin
                                if (i_channel) begin
                                    n_right_cnt = r_right_cnt + 1'b1;
                                end else begin
                                    n_left_cnt = r_left_cnt + 1'b1;
                                end
                                if (ld_mag > r_peak) begin
                                    n_peak = ld_mag;
                                end
                            end
                        end
                        OP_FETCH: begin
                            if (cur_loc.found) begin
                                n_pend_ch   = cur_loc.ch;
                                n_pend_exh  = 1'b0;
                                n_rd_ch     = cur_loc.ch;
                                n_rd_idx    = cur_loc.idx + 1'b1;
                                n_state     = S_READ;
                            end else begin
                                n_pend_sample = '0;
                                n_pend_ch     = 1'b0;
                                n_pend_last   = 1'b0;
                                n_pend_exh    = 1'b1;
                                n_state       = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_peak      = '0;
                            n_left_cnt  = '0;
                            n_right_cnt = '0;
                            n_rd_ch     = 1'b0;
                            n_rd_idx    = '0;
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // read position already advanced, so look one ahead for last
                n_pend_last = !nxt_loc.found;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_pend_sample = div_rsp.result;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_pend_sample;
                    n_out_ch     = r_pend_ch;
                    n_out_last   = r_pend_last;
                    n_out_exh    = r_pend_exh;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_MONO;
            r_peak      <= '0;
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
            r_rd_ch     <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_peak      <= n_peak;
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            r_rd_ch     <= n_rd_ch;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
        r_pend_sample <= n_pend_sample;
        r_pend_ch     <= n_pend_ch;
        r_pend_last   <= n_pend_last;
        r_pend_exh    <= n_pend_exh;
        r_out_sample  <= n_out_sample;
        r_out_ch      <= n_out_ch;
        r_out_last    <= n_out_last;
        r_out_exh     <= n_out_exh;
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_out_channel = r_out_ch;
    assign o_last_sample = r_out_last;
    assign o_exhausted   = r_out_exh;

    `PNB_ASSERT(a_done_in_div, i_clk, i_rst_n, !div_rsp.done || (r_state == S_DIV), "divider done outside divide state")
    `PNB_ASSERT(a_cnt_bound, i_clk, i_rst_n, (r_left_cnt <= CNT_W'(BUFFER_DEPTH)) && (r_right_cnt <= CNT_W'(BUFFER_DEPTH)), "sample count above depth")
    `PNB_ASSERT(a_exh_zero, i_clk, i_rst_n, !(r_out_valid && r_out_exh) || ((r_out_sample == '0) && !r_out_last && !r_out_ch), "exhausted beat with nonzero fields")
    `PNB_ASSERT_NEXT(a_fetch_read, i_clk, i_rst_n, in_accept && (i_op == OP_FETCH) && cur_loc.found, r_state == S_READ, "found fetch did not start a read")

endmodule

[src/pnb_ram.sv]
// ----------------------------------------------------------------------------
// pnb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pnb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/pnb_divider.sv]
// ----------------------------------------------------------------------------
// pnb_divider
// serial restoring divider: one quotient bit per cycle, with sign,
// saturation and zero-peak handling
// ----------------------------------------------------------------------------
module pnb_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pnb_pkg::t_div_req i_req,
    output pnb_pkg::t_div_rsp o_rsp
);
    import pnb_pkg::*;

    localparam logic [SAMPLE_WIDTH-1:0] Q_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic                    r_run, n_run;
    logic                    r_done, n_done;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [SAMPLE_WIDTH:0]   r_rem, n_rem;
    logic [SAMPLE_WIDTH-1:0] r_quot, n_quot;
    logic [SAMPLE_WIDTH-1:0] r_peak, n_peak;
    logic [SAMPLE_WIDTH-1:0] r_res, n_res;
    logic                    r_neg, n_neg;
    logic                    r_zero, n_zero;

    logic [SAMPLE_WIDTH:0]   diff;
    logic [SAMPLE_WIDTH:0]   rem_sel;
    logic                    q_bit;
    logic [SAMPLE_WIDTH-1:0] q_fin;
    logic [SAMPLE_WIDTH-1:0] q_sat;
    logic [SAMPLE_WIDTH-1:0] mag_in;

    always_comb begin
        mag_in  = i_req.sample[SAMPLE_WIDTH-1] ? (~i_req.sample + 1'b1) : i_req.sample;
        q_bit   = (r_rem >= {1'b0, r_peak});
        diff    = r_rem - {1'b0, r_peak};
        rem_sel = q_bit ? diff : r_rem;
        q_fin   = {r_quot[SAMPLE_WIDTH-2:0], q_bit};
        // the integer quotient bit is set, and the result saturated, when the sample magnitude is at or above the peak
        q_sat   = q_fin[SAMPLE_WIDTH-1] ? Q_MAX : q_fin;

        n_run  = r_run;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_peak = r_peak;
        n_res  = r_res;
        n_neg  = r_neg;
        n_zero = r_zero;

        if (r_run) begin
            n_quot = q_fin;
            n_rem  = {rem_sel[SAMPLE_WIDTH-1:0], 1'b0};
            if (r_step == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
                if (r_zero) begin
                    n_res = '0;
                end else if (r_neg) begin
                    n_res = ~q_sat + 1'b1;
                end else begin
                    n_res = q_sat;
                end
            end else begin
                n_step = r_step - 1'b1;
            end
        end else if (i_req.start) begin
            n_run  = 1'b1;
            n_step = STEP_W'(SAMPLE_WIDTH - 1);
            n_rem  = {1'b0, mag_in};
            n_quot = '0;
            n_peak = i_req.peak;
            n_neg  = i_req.sample[SAMPLE_WIDTH-1];
            n_zero = (i_req.peak == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_peak <= n_peak;
        r_res  <= n_res;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule
